>>> rtl/aeps_pkg.sv
// ----------------------------------------------------------------------------
// aeps_pkg: shared types and constants
// Entry layout, controller command and datapath status bundles.
// ----------------------------------------------------------------------------
package aeps_pkg;

  localparam int IdW    = 10;
  localparam int PrW    = 8;
  localparam int TimeW  = 8;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 8;

  localparam logic [CfgIdxW-1:0] RegRtQuantum  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegNrtQuantum = 2'd1;
  localparam logic [CfgIdxW-1:0] RegNrtPenalty = 2'd2;

  localparam logic [7:0] RtQuantumReset  = 8'd30;
  localparam logic [7:0] NrtQuantumReset = 8'd10;
  localparam logic [3:0] NrtPenaltyReset = 4'd5;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [PrW-1:0]   pr;
    logic             nrt;
    logic [TimeW-1:0] bt;
    logic [TimeW-1:0] ts;
  } entry_t;

  typedef struct packed {
    logic load_in;      // capture request
    logic scan_start;   // begin position scan for insert
    logic scan_step;    // compare one entry
    logic shift_step;   // move one entry up
    logic ins_write;    // write new entry, bump count
    logic ins_drop;     // flag drop
    logic slice_end;    // retire running task
    logic swap_check;   // swap queues if active empty, expired not
    logic pop_read;     // read head
    logic pop_step;     // move one entry down
    logic pop_done;     // finish dispatch
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic is_slice;
    logic ins_to_exp;   // insert target is expired queue
    logic target_full;
    logic retired;      // running task finished, skip insert
    logic scan_done;
    logic shift_done;
    logic act_empty;
    logic pop_shift_done;
    logic rd_pending;
  } status_t;

endpackage

>>> rtl/aeps_datapath.sv
// ----------------------------------------------------------------------------
// aeps_datapath: queue memories, counters and running task
// Two queue memories sharing one read port and one write port, one entry per step.
// ----------------------------------------------------------------------------
module aeps_datapath #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  aeps_pkg::cmd_t       cmd,
  output aeps_pkg::status_t    sts,
  input  logic                 in_req_type,
  input  aeps_pkg::entry_t     in_entry,
  input  logic [7:0]           rt_quantum,
  input  logic [7:0]           nrt_quantum,
  input  logic [3:0]           nrt_penalty,
  output logic [31:0]          result
);
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  aeps_pkg::entry_t mem_a [QUEUE_DEPTH];
  aeps_pkg::entry_t mem_b [QUEUE_DEPTH];
  logic [CW-1:0] count_a, count_b;
  logic          active_is_b, busy;
  aeps_pkg::entry_t running_task;
  aeps_pkg::entry_t new_e;
  logic          req_slice, to_exp;
  logic [CW-1:0] pos, idx;
  logic          rd_pending;
  aeps_pkg::entry_t rd_data;
  logic          fin_v, dis_v, swapped, drop;
  logic [9:0]    fin_id, dis_id;
  logic [7:0]    slice;

  logic          sel_b;
  logic [CW-1:0] tgt_count, act_count, exp_count;
  assign act_count = active_is_b ? count_b : count_a;
  assign exp_count = active_is_b ? count_a : count_b;
  assign tgt_count = to_exp ? exp_count : act_count;
  assign sel_b     = to_exp ? ~active_is_b : active_is_b;

  logic [8:0] pen_sum;
  assign pen_sum = {1'b0, running_task.pr} + {5'd0, nrt_penalty};

  logic requeue;
  aeps_finish_gate u_gate (
    .ts(running_task.ts), .bt(running_task.bt), .requeue(requeue)
  );

  aeps_pkg::entry_t requeue_e;
  always_comb begin
    requeue_e = running_task;
    if (running_task.nrt) requeue_e.pr = pen_sum[8] ? 8'hFF : pen_sum[7:0];
  end

  logic [7:0] q, rem, s;
  assign q   = rd_data.nrt ? nrt_quantum : rt_quantum;
  assign rem = (rd_data.ts < rd_data.bt) ? rd_data.bt - rd_data.ts : 8'd0;
  assign s   = (rem < q) ? rem : q;

  aeps_pkg::entry_t disp_e;
  always_comb begin
    disp_e    = rd_data;
    disp_e.ts = rd_data.ts + s;
  end

  // read port: scan at idx, shift below idx, head, pop shift above idx
  logic          rd_en;
  logic [CW-1:0] rd_addr;
  logic          rd_b;
  always_comb begin
    rd_en   = cmd.scan_step | cmd.shift_step | cmd.pop_read | cmd.pop_step;
    rd_b    = (cmd.pop_read | cmd.pop_step) ? active_is_b : sel_b;
    rd_addr = idx;
    if (cmd.shift_step) rd_addr = rd_pending ? idx - CW'(2) : idx - CW'(1);
    if (cmd.pop_read) rd_addr = '0;
    if (cmd.pop_step) rd_addr = idx + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= rd_b ? mem_b[rd_addr[AW-1:0]] : mem_a[rd_addr[AW-1:0]];
  end

  // write port
  logic          wr_en, wr_b;
  logic [CW-1:0] wr_addr;
  aeps_pkg::entry_t wr_data;
  always_comb begin
    wr_en = 1'b0; wr_b = sel_b; wr_addr = idx; wr_data = rd_data;
    if (cmd.shift_step && rd_pending) begin
      wr_en = 1'b1; wr_addr = idx;
    end else if (cmd.ins_write) begin
      wr_en = 1'b1; wr_addr = pos; wr_data = new_e;
    end else if (cmd.pop_step && rd_pending) begin
      wr_en = 1'b1; wr_b = active_is_b; wr_addr = idx - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_b) mem_b[wr_addr[AW-1:0]] <= wr_data;
      else mem_a[wr_addr[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a <= '0; count_b <= '0; active_is_b <= 1'b0; busy <= 1'b0;
      rd_pending <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        req_slice <= in_req_type;
        to_exp    <= in_req_type;
        new_e     <= in_entry;
        fin_v <= 1'b0; fin_id <= '0; dis_v <= 1'b0; dis_id <= '0;
        slice <= '0; swapped <= 1'b0; drop <= 1'b0;
        rd_pending <= 1'b0;
      end
      if (cmd.slice_end) begin
        busy <= 1'b0;
        if (requeue) begin
          new_e <= requeue_e;
        end else begin
          fin_v <= 1'b1; fin_id <= running_task.id;
        end
      end
      if (cmd.scan_start) begin
        idx <= '0; pos <= '0; rd_pending <= 1'b0;
      end
      if (cmd.scan_step) begin
        // compare previous read, then read idx
        if (rd_pending && new_e.pr < rd_data.pr) begin
          idx <= tgt_count; rd_pending <= 1'b0;
        end else begin
          if (rd_pending) pos <= pos + CW'(1);
          idx <= idx + CW'(1);
          rd_pending <= idx < tgt_count;
        end
      end
      if (cmd.shift_step) begin
        if (!rd_pending) begin
          rd_pending <= 1'b1;
        end else begin
          idx <= idx - CW'(1);
          rd_pending <= (idx - CW'(1)) > pos;
        end
      end
      if (cmd.ins_write) begin
        rd_pending <= 1'b0;
        if (sel_b) count_b <= count_b + CW'(1);
        else count_a <= count_a + CW'(1);
      end
      if (cmd.ins_drop) drop <= 1'b1;
      if (cmd.swap_check && busy == 1'b0 && req_slice && act_count == '0
          && exp_count != '0) begin
        active_is_b <= ~active_is_b; swapped <= 1'b1;
      end
      if (cmd.pop_read) begin
        idx <= '0; rd_pending <= 1'b0;
      end
      if (cmd.pop_step) begin
        if (!rd_pending) begin
          running_task <= disp_e;
          dis_v <= 1'b1; dis_id <= rd_data.id; slice <= s;
        end
        rd_pending <= 1'b1;
        idx <= idx + CW'(1);
      end
      if (cmd.pop_done) begin
        busy <= 1'b1; rd_pending <= 1'b0;
        if (active_is_b) count_b <= count_b - CW'(1);
        else count_a <= count_a - CW'(1);
      end
    end
  end

  always_comb begin
    sts.busy           = busy;
    sts.is_slice       = req_slice;
    sts.ins_to_exp     = to_exp;
    sts.target_full    = tgt_count >= CW'(QUEUE_DEPTH);
    sts.retired        = fin_v;
    sts.scan_done      = (idx >= tgt_count) && !rd_pending;
    sts.shift_done     = !rd_pending && (idx <= pos || pos >= tgt_count);
    sts.act_empty      = act_count == '0;
    sts.pop_shift_done = (idx + CW'(1)) >= act_count;
    sts.rd_pending     = rd_pending;
  end

  assign result = {drop, swapped, slice, dis_id, dis_v, fin_id, fin_v};
endmodule

>>> rtl/aeps_ctrl.sv
// ----------------------------------------------------------------------------
// aeps_ctrl: sequencing controller
// Steps one request through retire, sorted insert, swap and dispatch.
// ----------------------------------------------------------------------------
module aeps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output aeps_pkg::cmd_t    cmd,
  input  aeps_pkg::status_t sts
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SCAN_INIT, S_SCAN, S_SHIFT, S_WRITE, S_SWAP,
    S_POP, S_POP_SHIFT, S_POP_DONE, S_OUT
  } state_t;
  state_t state;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:      cmd.load_in = in_fire;
      S_DECODE:    cmd.slice_end = sts.is_slice && sts.busy;
      S_SCAN_INIT: begin
        if (!sts.retired) begin
          if (sts.target_full) cmd.ins_drop = 1'b1;
          else cmd.scan_start = 1'b1;
        end
      end
      S_SCAN:      cmd.scan_step = !sts.scan_done;
      S_SHIFT:     cmd.shift_step = !sts.shift_done;
      S_WRITE:     cmd.ins_write = 1'b1;
      S_SWAP:      cmd.swap_check = 1'b1;
      S_POP:       cmd.pop_read = !sts.busy && !sts.act_empty;
      S_POP_SHIFT: cmd.pop_step = 1'b1;
      S_POP_DONE:  cmd.pop_done = 1'b1;
      S_OUT:       cmd = '0;
      default:     cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:      if (in_fire) state <= S_DECODE;
        S_DECODE: begin
          if (!sts.is_slice) state <= S_SCAN_INIT;
          else if (!sts.busy) state <= S_POP;
          else state <= S_SCAN_INIT;
        end
        S_SCAN_INIT: begin
          // a finished task skips the insert
          priority if (sts.retired) state <= S_SWAP;
          else if (sts.target_full) state <= sts.is_slice ? S_SWAP : S_POP;
          else state <= S_SCAN;
        end
        S_SCAN:      if (sts.scan_done) state <= S_SHIFT;
        S_SHIFT:     if (sts.shift_done) state <= S_WRITE;
        S_WRITE:     state <= sts.is_slice ? S_SWAP : S_POP;
        S_SWAP:      state <= S_POP;
        S_POP:       state <= (!sts.busy && !sts.act_empty) ? S_POP_SHIFT : S_OUT;
        S_POP_SHIFT: if (sts.rd_pending && sts.pop_shift_done) state <= S_POP_DONE;
        S_POP_DONE:  state <= S_OUT;
        S_OUT:       if (out_ready) state <= S_IDLE;
        default:     state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/aeps_finish_gate.sv
// ----------------------------------------------------------------------------
// aeps_finish_gate: retire decision
// Tells whether a retired task needs re-queueing.
// ----------------------------------------------------------------------------
module aeps_finish_gate (
  input  logic [7:0] ts,
  input  logic [7:0] bt,
  output logic       requeue
);
  assign requeue = ts < bt;
endmodule

>>> rtl/active_expired_priority_scheduler.sv
// ----------------------------------------------------------------------------
// active_expired_priority_scheduler: two-queue priority task scheduler
// Sorted insert into active or expired queue, swap on empty, head dispatch.
// ----------------------------------------------------------------------------
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata, tuser = req_type
// m_axis    out  m_axis_tvalid/tready      tdata
// cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data
// A request scans the queue its task enters up to the slot and shifts the
// tail up, one entry per cycle; a dispatch then shifts the active queue
// down, one entry per cycle.
// Reset clears counts, queue selection and busy; memories need no clearing.
// A waiting result holds the block until m_axis_tready.
// ----------------------------------------------------------------------------
module active_expired_priority_scheduler #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // task_id, priority_req, non_realtime, burst_time
  input  logic        s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // finished_valid, finished_id, dispatch_valid,
                                     // dispatch_id, slice_length, queues_swapped, dropped
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  logic [7:0] rt_quantum, nrt_quantum;
  logic [3:0] nrt_penalty;
  aeps_pkg::cmd_t    cmd;
  aeps_pkg::status_t sts;
  aeps_pkg::entry_t  in_entry;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      rt_quantum  <= aeps_pkg::RtQuantumReset;
      nrt_quantum <= aeps_pkg::NrtQuantumReset;
      nrt_penalty <= aeps_pkg::NrtPenaltyReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        aeps_pkg::RegRtQuantum:  rt_quantum  <= cfg_data;
        aeps_pkg::RegNrtQuantum: nrt_quantum <= cfg_data;
        aeps_pkg::RegNrtPenalty: nrt_penalty <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign in_entry.id  = s_axis_tdata[9:0];
  assign in_entry.pr  = s_axis_tdata[17:10];
  assign in_entry.nrt = s_axis_tdata[18];
  assign in_entry.bt  = s_axis_tdata[26:19];
  assign in_entry.ts  = 8'd0;

  aeps_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_fire(s_axis_tvalid & s_axis_tready), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .cmd(cmd), .sts(sts)
  );

  aeps_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_req_type(s_axis_tuser), .in_entry(in_entry),
    .rt_quantum(rt_quantum), .nrt_quantum(nrt_quantum), .nrt_penalty(nrt_penalty),
    .result(m_axis_tdata)
  );
endmodule

>>> bench/aeps_checker.sv
// ----------------------------------------------------------------------------
// aeps_checker: result predictor and scoreboard
// Tracks both queues, the running task and the slice settings, then compares
// every m_axis transfer against the oldest expected result field by field.
// ----------------------------------------------------------------------------
module aeps_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDepth = 64;

  typedef struct packed {
    logic                       drop;
    logic                       swapped;
    logic [aeps_pkg::TimeW-1:0] slice;
    logic [aeps_pkg::IdW-1:0]   dis_id;
    logic                       dis_v;
    logic [aeps_pkg::IdW-1:0]   fin_id;
    logic                       fin_v;
  } sched_res_t;

  aeps_pkg::entry_t queue_a[$];
  aeps_pkg::entry_t queue_b[$];
  aeps_pkg::entry_t running;
  bit         act_b;
  bit         cpu_busy;
  logic [7:0] rt_q;
  logic [7:0] nrt_q;
  logic [3:0] penalty;
  sched_res_t expected_res[$];

  function automatic bit sorted_put(ref aeps_pkg::entry_t q[$], input aeps_pkg::entry_t e);
    int pos;
    pos = 0;
    if (q.size() >= QDepth) return 0;
    while (pos < q.size() && e.pr >= q[pos].pr) pos++;
    q.insert(pos, e);
    return 1;
  endfunction

  function automatic sched_res_t schedule_step(bit slice_end, logic [31:0] d);
    sched_res_t       r;
    aeps_pkg::entry_t t;
    int         p;
    int         act_n;
    int         exp_n;
    logic [7:0] qnt;
    logic [7:0] rem;
    bit         ok;
    r = '0;
    if (slice_end) begin
      if (cpu_busy) begin
        t = running;
        cpu_busy = 0;
        if (t.ts < t.bt) begin
          if (t.nrt) begin
            p = int'(t.pr) + int'(penalty);
            t.pr = (p > 255) ? 8'd255 : p[7:0];
          end
          ok = act_b ? sorted_put(queue_a, t) : sorted_put(queue_b, t);
          r.drop = !ok;
        end else begin
          r.fin_v = 1;
          r.fin_id = t.id;
        end
        act_n = act_b ? queue_b.size() : queue_a.size();
        exp_n = act_b ? queue_a.size() : queue_b.size();
        if (act_n == 0 && exp_n != 0) begin
          act_b = !act_b;
          r.swapped = 1;
        end
      end
    end else begin
      t.id = d[9:0];
      t.pr = d[17:10];
      t.nrt = d[18];
      t.bt = d[26:19];
      t.ts = '0;
      ok = act_b ? sorted_put(queue_b, t) : sorted_put(queue_a, t);
      r.drop = !ok;
    end
    act_n = act_b ? queue_b.size() : queue_a.size();
    if (!cpu_busy && act_n != 0) begin
      t = act_b ? queue_b.pop_front() : queue_a.pop_front();
      qnt = t.nrt ? nrt_q : rt_q;
      rem = (t.ts < t.bt) ? t.bt - t.ts : 8'd0;
      r.slice = (rem < qnt) ? rem : qnt;
      t.ts = t.ts + r.slice;
      running = t;
      cpu_busy = 1;
      r.dis_v = 1;
      r.dis_id = t.id;
    end
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    fails++;
  endtask

  initial begin
    fails = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    sched_res_t g;
    sched_res_t w;
    if (rst) begin
      queue_a.delete();
      queue_b.delete();
      act_b = 0;
      cpu_busy = 0;
      rt_q = aeps_pkg::RtQuantumReset;
      nrt_q = aeps_pkg::NrtQuantumReset;
      penalty = aeps_pkg::NrtPenaltyReset;
      expected_res.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          aeps_pkg::RegRtQuantum: rt_q = cfg_data;
          aeps_pkg::RegNrtQuantum: nrt_q = cfg_data;
          aeps_pkg::RegNrtPenalty: penalty = cfg_data[3:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_res.push_back(schedule_step(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        g = m_axis_tdata;
        if (expected_res.size() == 0) begin
          $display("[%0t] unexpected transfer %h", $time, m_axis_tdata);
          fails++;
        end else begin
          w = expected_res.pop_front();
          if (g.fin_v !== w.fin_v) report("finished_valid", g.fin_v, w.fin_v);
          if (g.fin_id !== w.fin_id) report("finished_id", g.fin_id, w.fin_id);
          if (g.dis_v !== w.dis_v) report("dispatch_valid", g.dis_v, w.dis_v);
          if (g.dis_id !== w.dis_id) report("dispatch_id", g.dis_id, w.dis_id);
          if (g.slice !== w.slice) report("slice_length", g.slice, w.slice);
          if (g.swapped !== w.swapped) report("queues_swapped", g.swapped, w.swapped);
          if (g.drop !== w.drop) report("dropped", g.drop, w.drop);
        end
      end
    end
    pending <= expected_res.size();
  end

endmodule

>>> bench/tb_active_expired_priority_scheduler.sv
// ----------------------------------------------------------------------------
// tb_active_expired_priority_scheduler: scheduler stimulus and verdict
// Drives arrivals and slice ends with random gaps and stalls across several
// slice settings, including queue overflow; the checker scores the results.
// ----------------------------------------------------------------------------
module tb_active_expired_priority_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;  // task_id, priority_req, non_realtime, burst_time
  logic        s_axis_tuser;  // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;  // finished_valid, finished_id, dispatch_valid,
                              // dispatch_id, slice_length, queues_swapped, dropped
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  int          fails;
  int          pending;
  bit          no_gaps;
  bit          sink_no_stall;

  localparam bit ReqArrival  = 1'b0;
  localparam bit ReqSliceEnd = 1'b1;

  active_expired_priority_scheduler i_dut (.*);

  aeps_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int n;
    m_axis_tready = 0;
    forever begin
      n = sink_no_stall ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        m_axis_tready <= 0;
        repeat (n) @(posedge clk);
      end
      m_axis_tready <= 1;
      forever begin
        @(negedge clk);
        if (m_axis_tvalid && m_axis_tready) begin
          @(posedge clk);
          break;
        end
      end
    end
  end

  task automatic send(bit rq, logic [9:0] id, logic [7:0] pr, bit nrt, logic [7:0] bt);
    int n;
    n = no_gaps ? 0 : $urandom_range(0, 4);
    if (n > 0) begin
      s_axis_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= rq;
    s_axis_tdata <= {5'd0, bt, nrt, pr, id};
    forever begin
      @(negedge clk);
      if (s_axis_tready) begin
        @(posedge clk);
        break;
      end
    end
  endtask

  task automatic send_random(int slice_pct);
    logic [7:0] bt;
    logic [7:0] pr;
    bt = ($urandom_range(0, 99) < 3) ? 8'd0 : 8'($urandom_range(1, 40));
    if ($urandom_range(0, 9) == 0) bt = 8'($urandom);
    pr = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(240, 255)) : 8'($urandom);
    send($urandom_range(0, 99) < slice_pct ? ReqSliceEnd : ReqArrival,
         10'($urandom), pr, 1'($urandom), bt);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    forever begin
      @(negedge clk);
      if (cfg_ready) begin
        @(posedge clk);
        break;
      end
    end
  endtask

  task automatic set_slices(logic [7:0] rt, logic [7:0] nrt, logic [7:0] pen);
    drain();
    write_reg(aeps_pkg::RegRtQuantum, rt);
    write_reg(aeps_pkg::RegNrtQuantum, nrt);
    write_reg(aeps_pkg::RegNrtPenalty, pen);
    cfg_valid <= 0;
  endtask

  task automatic random_run(int items);
    for (int i = 0; i < items; i++) begin
      if (i % 100 == 0) begin
        no_gaps = $urandom_range(0, 3) == 0;
        sink_no_stall = $urandom_range(0, 3) == 0;
      end
      if (i == items / 2) drain();
      send_random(i % 200 < 100 ? 45 : 55);
    end
  endtask

  initial begin
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = 0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    no_gaps = 0;
    sink_no_stall = 0;
    rst = 1;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(ReqSliceEnd, 10'h3ff, 8'hff, 1, 8'hff);
    send(ReqArrival, 10'd0, 8'd0, 0, 8'd1);
    send(ReqArrival, 10'd1023, 8'd255, 1, 8'd255);
    send(ReqArrival, 10'd5, 8'd255, 1, 8'd40);
    send(ReqArrival, 10'd6, 8'd7, 0, 8'd0);
    send(ReqArrival, 10'd7, 8'd7, 1, 8'd12);
    send(ReqArrival, 10'd8, 8'd0, 0, 8'd100);
    for (int i = 0; i < 16; i++) send(ReqSliceEnd, '0, '0, 0, '0);
    send(ReqSliceEnd, 10'h3ff, 8'hff, 1, 8'hff);

    set_slices(8'd1, 8'd1, 8'd0);
    random_run(300);
    set_slices(8'd255, 8'd255, 8'd15);
    for (int i = 0; i < 70; i++) send(ReqArrival, 10'($urandom), 8'($urandom), 1, 8'd200);
    for (int i = 0; i < 70; i++) send(ReqSliceEnd, 10'($urandom), '0, 0, '0);
    random_run(300);
    set_slices(8'd0, 8'd3, 8'd15);
    random_run(100);
    set_slices(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
               8'($urandom_range(0, 15)));
    random_run(300);
    set_slices(8'd30, 8'd10, 8'd5);
    random_run(300);

    drain();
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/aeps_pkg.sv
rtl/aeps_datapath.sv
rtl/aeps_ctrl.sv
rtl/aeps_finish_gate.sv
rtl/active_expired_priority_scheduler.sv
bench/aeps_checker.sv
bench/tb_active_expired_priority_scheduler.sv
